// File: src/alpha_weighted_box_downsample_top_defines.svh
// Assertion macros shared by the RTL files
`ifndef ALPHA_WEIGHTED_BOX_DOWNSAMPLE_TOP_DEFINES_SVH
`define ALPHA_WEIGHTED_BOX_DOWNSAMPLE_TOP_DEFINES_SVH

// Implication checked on every edge outside reset
`define AWBD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Implication checked on every edge, reset included
`define AWBD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// File: src/awbd_pkg.sv
package awbd_pkg;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FACTOR = 2'd2;

    // Accumulator widths
    localparam int unsigned AW = 16;
    localparam int unsigned CW = 24;
    localparam int unsigned SW = AW + 3 * CW;

    // Sums for one output column
    typedef struct packed {
        logic [AW-1:0] a;
        logic [CW-1:0] r;
        logic [CW-1:0] g;
        logic [CW-1:0] b;
    } t_sums;

    // Request to the divide unit
    typedef struct packed {
        logic [CW-1:0] r;
        logic [CW-1:0] g;
        logic [CW-1:0] b;
        logic [AW-1:0] a;
        logic [AW-1:0] asum_num;
        logic [9:0]    samples;
        logic          last;
    } t_div_req;

endpackage

// File: src/alpha_weighted_box_downsample_top.sv
// Alpha-weighted box downsampler.
// Input channel: i_valid / o_stall with i_source_pixel (AARRGGBB) in raster order.
// Output channel: o_valid / i_stall with o_reduced_pixel and o_image_done, the
// latter set on the final output pixel of the image.
// Configuration: i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data; registers
// 0 width, 1 height, 2 factor. A write to one of them restarts the image at
// position (0, 0). Per-column sums live in a 1024-entry synchronous RAM; each
// pixel is read as it is accepted and written back in state S_RD, where no
// further pixel is accepted, so a pixel waits for the last one's write-back.
// A block's last pixel starts the divider (one quotient bit a cycle per
// channel); while it works no pixel is accepted. When it is done, state S_OUT
// loads the result and raises o_valid, and the block returns to S_IDLE for
// the next pixel. The result sits in an output register until taken; a stall
// there holds it and the next completing pixel waits.
// Reset (synchronous, active low) restores width 1024, height 1024, factor 2
// and position (0, 0); RAM contents are not cleared, as a block's first pixel
// always overwrites its entry.
module alpha_weighted_box_downsample_top #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024,
    parameter int unsigned MAX_FACTOR = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_source_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_reduced_pixel,
    output logic        o_image_done,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    localparam int unsigned XW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned YW = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned FW = $clog2(MAX_FACTOR + 1);
    localparam int unsigned CA = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    typedef enum logic [1:0] {S_IDLE, S_RD, S_DIV, S_OUT} t_state;

    t_state            r_state;
    logic [10:0]       r_w, r_h;
    logic [4:0]        r_f;
    logic [XW-1:0]     r_x;
    logic [YW-1:0]     r_y;
    logic [FW-1:0]     r_ix, r_iy;
    logic [CA-1:0]     r_col;
    logic [XW-1:0]     r_ocol;
    logic [XW-1:0]     r_bx;
    logic [YW-1:0]     r_by;
    logic [31:0]       r_px;
    logic              r_use, r_first, r_fin, r_lastblk;
    logic              r_ovalid;
    logic [31:0]       r_opix;
    logic              r_odone;

    awbd_pkg::t_sums   w_rd, w_wr;
    awbd_pkg::t_div_req w_req;
    logic              w_we, w_start, w_dbusy, w_ddone, w_dlast, w_acc;
    logic [31:0]       w_dpix;
    logic [7:0]        w_a;
    logic [XW-1:0]     w_w_c;
    logic [YW-1:0]     w_h_c;
    logic [FW-1:0]     w_fc;
    logic [9:0]        w_samples;
    logic              w_cfg_hit;

    // Clamped register values
    function automatic logic [12:0] clampv(input logic [10:0] v, input int unsigned mx);
        logic [12:0] t;
        t = 13'(v);
        if (t == '0) t = 13'd1;
        if (32'(t) > mx) t = 13'(mx);
        return t;
    endfunction

    assign w_w_c     = XW'(clampv(r_w, MAX_WIDTH));
    assign w_h_c     = YW'(clampv(r_h, MAX_HEIGHT));
    assign w_fc      = (r_f == '0) ? FW'(1) :
                       ((32'(r_f) > MAX_FACTOR) ? FW'(MAX_FACTOR) : FW'(r_f));
    assign w_samples = 10'(w_fc * w_fc);

    assign o_cfg_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_stall     = (r_state != S_IDLE) || i_cfg_valid;
    assign w_acc       = i_valid && !o_stall;
    assign w_cfg_hit   = (i_cfg_index == awbd_pkg::REG_WIDTH) ||
                         (i_cfg_index == awbd_pkg::REG_HEIGHT) ||
                         (i_cfg_index == awbd_pkg::REG_FACTOR);

    // Accumulator RAM, one entry per output column
    awbd_ram #(.WIDTH(awbd_pkg::SW), .DEPTH(1 << CA)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_col),
        .i_wdata (w_wr),
        .i_raddr (CA'(r_ocol)),
        .o_rdata (w_rd)
    );

    // Read-modify-write of the column sums
    assign w_a = r_px[31:24];
    always_comb begin
        w_wr.a = (r_first ? '0 : w_rd.a) + awbd_pkg::AW'(w_a);
        w_wr.r = (r_first ? '0 : w_rd.r) + awbd_pkg::CW'(r_px[23:16] * w_a);
        w_wr.g = (r_first ? '0 : w_rd.g) + awbd_pkg::CW'(r_px[15:8] * w_a);
        w_wr.b = (r_first ? '0 : w_rd.b) + awbd_pkg::CW'(r_px[7:0] * w_a);
    end
    assign w_we    = (r_state == S_RD) && r_use;
    assign w_start = w_we && r_fin;

    always_comb begin
        w_req.r        = w_wr.r;
        w_req.g        = w_wr.g;
        w_req.b        = w_wr.b;
        w_req.a        = w_wr.a;
        w_req.asum_num = w_wr.a;
        w_req.samples  = w_samples;
        w_req.last     = r_lastblk;
    end

    awbd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (w_req),
        .o_busy  (w_dbusy),
        .o_done  (w_ddone),
        .o_pixel (w_dpix),
        .o_last  (w_dlast)
    );

    // Control, position counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_w      <= 11'd1024;
            r_h      <= 11'd1024;
            r_f      <= 5'd2;
            r_x      <= '0;
            r_y      <= '0;
            r_ix     <= '0;
            r_iy     <= '0;
            r_ocol   <= '0;
            r_bx     <= '0;
            r_by     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        unique case (i_cfg_index)
                            awbd_pkg::REG_WIDTH:  r_w <= i_cfg_data;
                            awbd_pkg::REG_HEIGHT: r_h <= i_cfg_data;
                            awbd_pkg::REG_FACTOR: r_f <= i_cfg_data[4:0];
                            default: ;
                        endcase
                        if (w_cfg_hit) begin
                            r_x <= '0; r_y <= '0; r_ix <= '0; r_iy <= '0;
                            r_ocol <= '0; r_bx <= '0; r_by <= '0;
                        end
                    end else if (w_acc) begin
                        r_state <= S_RD;
                        // Step position
                        if (r_x + 1'b1 >= w_w_c) begin
                            r_x    <= '0;
                            r_ix   <= '0;
                            r_ocol <= '0;
                            r_bx   <= '0;
                            if (r_y + 1'b1 >= w_h_c) begin
                                r_y <= '0; r_iy <= '0; r_by <= '0;
                            end else begin
                                r_y <= r_y + 1'b1;
                                if (r_iy + 1'b1 == w_fc) begin
                                    r_iy <= '0; r_by <= r_by + YW'(w_fc);
                                end else begin
                                    r_iy <= r_iy + 1'b1;
                                end
                            end
                        end else begin
                            r_x <= r_x + 1'b1;
                            if (r_ix + 1'b1 == w_fc) begin
                                r_ix <= '0; r_ocol <= r_ocol + 1'b1;
                                r_bx <= r_bx + XW'(w_fc);
                            end else begin
                                r_ix <= r_ix + 1'b1;
                            end
                        end
                    end
                end
                S_RD: r_state <= (r_use && r_fin) ? S_DIV : S_IDLE;
                S_DIV: if (w_ddone) r_state <= S_OUT;
                S_OUT: if (!r_ovalid || !i_stall) begin
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Per-item qualifiers, captured at acceptance; block start positions
    // decide whether the block lies wholly inside the image
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_px      <= i_source_pixel;
            r_col     <= CA'(r_ocol);
            r_use     <= (32'(r_bx) + 32'(w_fc) <= 32'(w_w_c)) &&
                         (32'(r_by) + 32'(w_fc) <= 32'(w_h_c));
            r_first   <= (r_ix == '0) && (r_iy == '0);
            r_fin     <= (r_ix + 1'b1 == w_fc) && (r_iy + 1'b1 == w_fc);
            r_lastblk <= (32'(r_bx) + 2 * 32'(w_fc) > 32'(w_w_c)) &&
                         (32'(r_by) + 2 * 32'(w_fc) > 32'(w_h_c));
        end
        if (r_state == S_OUT && (!r_ovalid || !i_stall)) begin
            r_opix  <= w_dpix;
            r_odone <= w_dlast;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_reduced_pixel = r_opix;
    assign o_image_done    = r_odone;

    `AWBD_ASSERT(a_div_only_in_div, i_clk, i_rst_n, (w_dbusy |-> r_state == S_DIV))
    `AWBD_ASSERT(a_no_accept_busy, i_clk, i_rst_n, (r_state != S_IDLE |-> !w_acc))
    `AWBD_ASSERT(a_write_after_read, i_clk, i_rst_n, (w_we |-> $past(w_acc)))

endmodule

// File: src/awbd_ram.sv
module awbd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Single write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: src/awbd_div.sv
`include "alpha_weighted_box_downsample_top_defines.svh"

// Restoring divider: four rounded quotients, one bit of each per cycle
module awbd_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  awbd_pkg::t_div_req  i_req,
    output logic                o_busy,
    output logic                o_done,
    output logic [31:0]         o_pixel,
    output logic                o_last
);

    localparam int unsigned NB = awbd_pkg::CW + 1;

    logic [4:0]                r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic                      r_zero;
    logic                      r_last;
    logic [NB-1:0]             r_num [4];
    logic [NB-1:0]             r_rem [4];
    logic [NB-1:0]             r_quo [4];
    logic [awbd_pkg::AW-1:0]   r_den [4];
    logic [NB-1:0]             n_rem [4];
    logic [NB-1:0]             w_try [4];

    // One restoring step for each lane
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_try[k] = {r_rem[k][NB-2:0], r_num[k][NB-1]};
            n_rem[k] = (w_try[k] >= NB'(r_den[k])) ? w_try[k] - NB'(r_den[k]) : w_try[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(NB - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 5'd1;
            end
        end
        // Datapath
        if (i_start) begin
            r_zero   <= (i_req.a == '0);
            r_last   <= i_req.last;
            r_num[0] <= NB'(i_req.asum_num) + NB'(i_req.samples >> 1);
            r_den[0] <= awbd_pkg::AW'(i_req.samples);
            r_num[1] <= NB'(i_req.r) + NB'(i_req.a >> 1);
            r_num[2] <= NB'(i_req.g) + NB'(i_req.a >> 1);
            r_num[3] <= NB'(i_req.b) + NB'(i_req.a >> 1);
            for (int k = 1; k < 4; k++) begin
                r_den[k] <= i_req.a;
            end
            for (int k = 0; k < 4; k++) begin
                r_rem[k] <= '0;
                r_quo[k] <= '0;
            end
        end else if (r_busy) begin
            for (int k = 0; k < 4; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= {r_quo[k][NB-2:0], (w_try[k] >= NB'(r_den[k]))};
                r_num[k] <= {r_num[k][NB-2:0], 1'b0};
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_done  = r_done;
    assign o_last  = r_last;
    assign o_pixel = r_zero ? 32'd0 :
        {r_quo[0][7:0], r_quo[1][7:0], r_quo[2][7:0], r_quo[3][7:0]};

    `AWBD_ASSERT(a_no_restart, i_clk, i_rst_n, (r_busy |-> !i_start))
    `AWBD_ASSERT(a_done_after_busy, i_clk, i_rst_n, (r_done |-> $past(r_busy)))
    `AWBD_ASSERT_ALWAYS(a_done_pulse, i_clk, (r_done |=> !r_done))

endmodule
